// ===== sv/cs_pkg.sv =====
// ----------------------------------------------------------------------------
// cs_pkg
// Shared constants for the min-max contrast stretch block.
// ----------------------------------------------------------------------------
package cs_pkg;

    localparam int PIXEL_BITS_DEFAULT = 8;
    localparam int PIXEL_W            = 8;
    localparam int LEVEL_W            = 8;
    localparam int CFG_INDEX_W        = 2;
    localparam int QUEUE_DEPTH        = 2;
    localparam int DIV_STEPS          = LEVEL_W;

    localparam logic [CFG_INDEX_W-1:0] REG_LOW_LEVEL  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_HIGH_LEVEL = CFG_INDEX_W'(1);

    localparam logic [LEVEL_W-1:0] LOW_LEVEL_RESET  = '0;
    localparam logic [LEVEL_W-1:0] HIGH_LEVEL_RESET = '1;

endpackage

// ===== sv/cs_front.sv =====
// ----------------------------------------------------------------------------
// cs_front
// Accepts pixels, tracks the running minimum and maximum during the measure
// pass and prepares clamped offsets for the stretch pass.
// ----------------------------------------------------------------------------
module cs_front
    import cs_pkg::*;
#(
    parameter int PB = PIXEL_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               mode,
    input  logic               first,
    input  logic [PIXEL_W-1:0] pixel,
    input  logic               queue_full,
    output logic               push,
    output logic               push_flat,
    output logic [PB-1:0]      push_off,
    output logic [PB-1:0]      push_span
);

    logic [PB-1:0]         min_reg;
    logic [PB-1:0]         min_next;
    logic [PB-1:0]         max_reg;
    logic [PB-1:0]         max_next;
    logic [PB+PIXEL_W-1:0] pix_wide;
    logic [PB-1:0]         pix;
    logic [PB-1:0]         clamped;
    logic                  accept;

    assign pix_wide = {{PB{1'b0}}, pixel};
    assign pix      = pix_wide[PB-1:0];
    assign in_stall = queue_full;
    assign accept   = in_valid && !queue_full;
    assign push     = accept && mode;

    always_comb
    begin
        if (pix < min_reg)
        begin
            clamped = min_reg;
        end
        else if (pix > max_reg)
        begin
            clamped = max_reg;
        end
        else
        begin
            clamped = pix;
        end
    end

    assign push_flat = (max_reg <= min_reg);
    assign push_off  = clamped - min_reg;
    assign push_span = max_reg - min_reg;

    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        if (accept && !mode)
        begin
            if (first)
            begin
                min_next = pix;
                max_next = pix;
            end
            else
            begin
                if (pix < min_reg)
                begin
                    min_next = pix;
                end
                if (pix > max_reg)
                begin
                    max_next = pix;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= '1;
            max_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

endmodule

// ===== sv/cs_queue.sv =====
// ----------------------------------------------------------------------------
// cs_queue
// Short first-in first-out queue between the front and the back.
// ----------------------------------------------------------------------------
module cs_queue
    import cs_pkg::*;
#(
    parameter int WIDTH = 1,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/cs_back.sv =====
// ----------------------------------------------------------------------------
// cs_back
// Scales each queued offset by the level range and divides it by the
// measured span with a serial restoring divider, then drives the output beat.
// ----------------------------------------------------------------------------
module cs_back
    import cs_pkg::*;
#(
    parameter int PB = PIXEL_BITS_DEFAULT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               queue_empty,
    output logic               pop,
    input  logic               pop_flat,
    input  logic [PB-1:0]      pop_off,
    input  logic [PB-1:0]      pop_span,
    input  logic [LEVEL_W-1:0] low_level,
    input  logic [LEVEL_W-1:0] high_level,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [LEVEL_W-1:0] value
);

    localparam int REM_W  = PB + LEVEL_W;
    localparam int STEP_W = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_DONE
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic               flat_reg;
    logic               flat_next;
    logic [PB-1:0]      off_reg;
    logic [PB-1:0]      off_next;
    logic [PB-1:0]      span_reg;
    logic [PB-1:0]      span_next;
    logic [REM_W-1:0]   rem_reg;
    logic [REM_W-1:0]   rem_next;
    logic [LEVEL_W-1:0] quo_reg;
    logic [LEVEL_W-1:0] quo_next;
    logic [STEP_W-1:0]  step_reg;
    logic [STEP_W-1:0]  step_next;
    logic               neg_reg;
    logic               neg_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [LEVEL_W-1:0] value_reg;
    logic [LEVEL_W-1:0] value_next;

    logic               neg;
    logic [LEVEL_W-1:0] mag;
    logic [REM_W-1:0]   trial;
    logic               fits;
    logic               out_free;
    logic [LEVEL_W-1:0] result;

    assign neg      = (high_level < low_level);
    assign mag      = neg ? (low_level - high_level) : (high_level - low_level);
    assign trial    = REM_W'(span_reg) << step_reg;
    assign fits     = (rem_reg >= trial);
    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == S_IDLE) && !queue_empty;
    assign result   = neg_reg
                    ? (low_level - quo_reg - LEVEL_W'(rem_reg != '0))
                    : (low_level + quo_reg);

    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    always_comb
    begin
        state_next     = state_reg;
        flat_next      = flat_reg;
        off_next       = off_reg;
        span_next      = span_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        step_next      = step_reg;
        neg_next       = neg_reg;
        value_next     = value_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!queue_empty)
                begin
                    flat_next  = pop_flat;
                    off_next   = pop_off;
                    span_next  = pop_span;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                neg_next  = neg;
                quo_next  = '0;
                step_next = STEP_W'(DIV_STEPS - 1);
                if (flat_reg)
                begin
                    rem_next   = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    rem_next   = REM_W'(off_reg) * REM_W'(mag);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (fits)
                begin
                    rem_next = rem_reg - trial;
                end
                quo_next = {quo_reg[LEVEL_W-2:0], fits};
                if (step_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    step_next = step_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    value_next     = result;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        flat_reg  <= flat_next;
        off_reg   <= off_next;
        span_reg  <= span_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        step_reg  <= step_next;
        neg_reg   <= neg_next;
        value_reg <= value_next;
    end

endmodule

// ===== sv/contrast_stretch.sv =====
// ----------------------------------------------------------------------------
// contrast_stretch
// Two-pass min-max linear contrast stretch of grey pixels.
// ----------------------------------------------------------------------------
// Measure pixels are taken one per cycle while the queue has room.
// In the back a stretch pixel is loaded, then multiplied, then put through
// eight divider steps and then written to the output register.
// A flat range skips the divider and goes straight to the output register.
// Reset clears the level registers to 0 and 255, the minimum to all ones,
// the maximum to zero, and empties the queue and the output register.
module contrast_stretch
    import cs_pkg::*;
#(
    parameter int PIXEL_BITS = PIXEL_BITS_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   mode,
    input  logic                   first,
    input  logic [PIXEL_W-1:0]     pixel,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [LEVEL_W-1:0]     value,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_data
);

    localparam int ENTRY_W = 2 * PIXEL_BITS + 1;

    logic [LEVEL_W-1:0]    low_level_reg;
    logic [LEVEL_W-1:0]    low_level_next;
    logic [LEVEL_W-1:0]    high_level_reg;
    logic [LEVEL_W-1:0]    high_level_next;

    logic                  push;
    logic                  push_flat;
    logic [PIXEL_BITS-1:0] push_off;
    logic [PIXEL_BITS-1:0] push_span;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  pop;
    logic [ENTRY_W-1:0]    pop_data;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        low_level_next  = low_level_reg;
        high_level_next = high_level_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_LOW_LEVEL:  low_level_next  = cfg_data;
                REG_HIGH_LEVEL: high_level_next = cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_level_reg  <= LOW_LEVEL_RESET;
            high_level_reg <= HIGH_LEVEL_RESET;
        end
        else
        begin
            low_level_reg  <= low_level_next;
            high_level_reg <= high_level_next;
        end
    end

    cs_front #(
        .PB (PIXEL_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .first      (first),
        .pixel      (pixel),
        .queue_full (queue_full),
        .push       (push),
        .push_flat  (push_flat),
        .push_off   (push_off),
        .push_span  (push_span)
    );

    cs_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_flat, push_off, push_span}),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    cs_back #(
        .PB (PIXEL_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_flat    (pop_data[ENTRY_W-1]),
        .pop_off     (pop_data[2*PIXEL_BITS-1:PIXEL_BITS]),
        .pop_span    (pop_data[PIXEL_BITS-1:0]),
        .low_level   (low_level_reg),
        .high_level  (high_level_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value)
    );

endmodule

// ===== sv/cs_checker.sv =====
// ----------------------------------------------------------------------------
// cs_checker
// Port-level checks for the contrast stretch block, bound to the top level.
// ----------------------------------------------------------------------------
module cs_checker
    import cs_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               mode,
    input logic               out_valid,
    input logic               out_stall,
    input logic [LEVEL_W-1:0] value
);

    localparam int MAX_PENDING = QUEUE_DEPTH + 2;
    localparam int PEND_W      = $clog2(MAX_PENDING + 2);

    logic              stretch_beat;
    logic              out_beat;
    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;

    assign stretch_beat = in_valid && !in_stall && mode;
    assign out_beat     = out_valid && !out_stall;
    assign pending_next = pending_reg + PEND_W'(stretch_beat) - PEND_W'(out_beat);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    // A stalled output beat keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(value))
        else $error("output beat changed while stalled");

    // An output beat is only offered for a stretch pixel not yet answered.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("output beat without an outstanding stretch pixel");

    // The block never holds more stretch pixels than it has room for.
    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= PEND_W'(MAX_PENDING))
        else $error("more stretch pixels outstanding than storage allows");

    // With every slot taken the input must be held off.
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == PEND_W'(MAX_PENDING) |-> in_stall)
        else $error("input not stalled with all slots occupied");

endmodule

bind contrast_stretch cs_checker u_cs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value     (value)
);

// ===== verif/contrast_stretch_tb_pkg.sv =====
// ----------------------------------------------------------------------------
// contrast_stretch_tb_pkg
// Codes shared by the contrast stretch testbench and its checker.
// ----------------------------------------------------------------------------
package contrast_stretch_tb_pkg;

    import cs_pkg::*;

    typedef enum logic
    {
        PASS_MEASURE = 1'b0,
        PASS_STRETCH = 1'b1
    } pass_t;

    // Indexes that the block decodes to no register.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = CFG_INDEX_W'(3);

endpackage

// ===== verif/contrast_stretch_checker.sv =====
// ----------------------------------------------------------------------------
// contrast_stretch_checker
// Watches the pixel, level and output channels of the contrast stretch block.
// Every accepted stretch pixel is turned into an expected grey level from a
// private copy of the levels and the running minimum and maximum, and every
// output beat is compared with the oldest expected level.
// ----------------------------------------------------------------------------
module contrast_stretch_checker
    import cs_pkg::*;
    import contrast_stretch_tb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   mode,
    input  logic                   first,
    input  logic [PIXEL_W-1:0]     pixel,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [LEVEL_W-1:0]     value,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]     cfg_data,
    output int                     n_failed,
    output int                     n_waiting
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [LEVEL_W-1:0] low_lvl;
    logic [LEVEL_W-1:0] high_lvl;
    logic [PIXEL_W-1:0] run_min;
    logic [PIXEL_W-1:0] run_max;
    logic [LEVEL_W-1:0] expected_levels[$];
    int                 beats_seen;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        n_failed++;
    endtask

    function automatic logic [LEVEL_W-1:0] stretched_level(input logic [PIXEL_W-1:0] p);
        int lo;
        int hi;
        int mn;
        int mx;
        int v;
        int num;
        int den;
        int q;
        lo = int'(low_lvl);
        hi = int'(high_lvl);
        mn = int'(run_min);
        mx = int'(run_max);
        v  = int'(p);
        if (mx <= mn)
        begin
            return low_lvl;
        end
        if (v < mn)
        begin
            v = mn;
        end
        if (v > mx)
        begin
            v = mx;
        end
        num = (v - mn) * (hi - lo);
        den = mx - mn;
        // A falling mapping must still round towards minus infinity.
        if (num >= 0)
        begin
            q = num / den;
        end
        else
        begin
            q = -((-num + den - 1) / den);
        end
        return LEVEL_W'(lo + q);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_lvl    = LOW_LEVEL_RESET;
            high_lvl   = HIGH_LEVEL_RESET;
            run_min    = '1;
            run_max    = '0;
            expected_levels.delete();
            beats_seen = 0;
            n_failed   = 0;
            n_waiting  = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOW_LEVEL)
                begin
                    low_lvl = cfg_data;
                end
                else if (cfg_index == REG_HIGH_LEVEL)
                begin
                    high_lvl = cfg_data;
                end
            end
            if (out_valid && !out_stall)
            begin
                if (expected_levels.size() == 0)
                begin
                    report_mismatch($sformatf("output beat %0d with value %0d was not expected",
                                              beats_seen, value));
                end
                else if (value !== expected_levels[0])
                begin
                    report_mismatch($sformatf("output beat %0d value %0d, expected %0d",
                                              beats_seen, value, expected_levels[0]));
                    void'(expected_levels.pop_front());
                end
                else
                begin
                    void'(expected_levels.pop_front());
                end
                beats_seen++;
            end
            if (in_valid && !in_stall)
            begin
                if (mode == PASS_STRETCH)
                begin
                    expected_levels.push_back(stretched_level(pixel));
                end
                else if (first)
                begin
                    run_min = pixel;
                    run_max = pixel;
                end
                else
                begin
                    if (pixel < run_min)
                    begin
                        run_min = pixel;
                    end
                    if (pixel > run_max)
                    begin
                        run_max = pixel;
                    end
                end
            end
            n_waiting = expected_levels.size();
        end
    end

endmodule

// ===== verif/contrast_stretch_tb.sv =====
// ----------------------------------------------------------------------------
// contrast_stretch_tb
// Stimulus and verdict for the min-max contrast stretch block.
// A directed run covers the empty and flat ranges, clamping, reversed levels
// and spare register indexes; then phases of measure and stretch sequences
// with random content run under several level settings, with the sender
// idling and the receiver stalling at different rates, and one long
// receiver hold-off that fills the block. The checker compares every beat.
// ----------------------------------------------------------------------------
module contrast_stretch_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import cs_pkg::*;
    import contrast_stretch_tb_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int DRAIN_TAIL  = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic                   mode;
    logic                   first;
    logic [PIXEL_W-1:0]     pixel;
    logic                   out_valid;
    logic                   out_stall;
    logic [LEVEL_W-1:0]     value;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [LEVEL_W-1:0]     cfg_data;

    int n_failed;
    int n_waiting;
    int in_idle_pct   = 0;
    int out_stall_pct = 0;
    int pressure_req  = 0;
    int pressure_seen = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    contrast_stretch dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .first     (first),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    contrast_stretch_checker u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .first     (first),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .n_failed  (n_failed),
        .n_waiting (n_waiting)
    );

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("contrast_stretch_tb NOT OK");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_req != pressure_seen)
            begin
                pressure_seen = pressure_req;
                hold_left     = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    task automatic send_pixel(input pass_t m, input logic f, input logic [PIXEL_W-1:0] p);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        first    <= f;
        pixel    <= p;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
    endtask

    task automatic write_level(input logic [CFG_INDEX_W-1:0] idx, input logic [LEVEL_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
    endtask

    task automatic set_levels(input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi,
                              input logic spare);
        write_level(REG_LOW_LEVEL, lo);
        write_level(REG_HIGH_LEVEL, hi);
        if (spare)
        begin
            write_level(REG_SPARE_2, LEVEL_W'($urandom_range(255)));
            write_level(REG_SPARE_3, LEVEL_W'($urandom_range(255)));
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (n_waiting != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic run_random(input int n_items);
        int                 done;
        int                 r;
        int                 n_meas;
        int                 n_str;
        int                 w_lo;
        int                 w_hi;
        logic [PIXEL_W-1:0] p;
        done = 0;
        while (done < n_items)
        begin
            r = $urandom_range(99);
            if (r < 12)
            begin
                send_pixel(pass_t'($urandom_range(1)), 1'($urandom_range(1)),
                           PIXEL_W'($urandom_range(255)));
                done++;
            end
            else
            begin
                w_lo = $urandom_range(255);
                w_hi = ($urandom_range(9) == 0) ? w_lo : w_lo + $urandom_range(255);
                if (w_hi > 255)
                begin
                    w_hi = 255;
                end
                n_meas = ($urandom_range(19) == 0) ? $urandom_range(64, 8) : $urandom_range(6, 1);
                n_str  = ($urandom_range(19) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
                // Some measure runs carry no first flag and keep widening the range.
                for (int i = 0; i < n_meas; i++)
                begin
                    send_pixel(PASS_MEASURE, (i == 0) && (r >= 22),
                               PIXEL_W'($urandom_range(w_hi, w_lo)));
                end
                for (int i = 0; i < n_str; i++)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        p = PIXEL_W'($urandom_range(255));
                    end
                    else
                    begin
                        p = PIXEL_W'($urandom_range(w_hi, w_lo));
                    end
                    send_pixel(PASS_STRETCH, 1'($urandom_range(1)), p);
                end
                done += n_meas + n_str;
            end
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct,
                             input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi,
                             input int n_items, input logic pressure);
        drain_idle();
        set_levels(lo, hi, 1'($urandom_range(1)));
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        if (pressure)
        begin
            pressure_req++;
        end
        run_random(n_items);
    endtask

    task automatic run_directed();
        send_pixel(PASS_STRETCH, 1'b0, 8'd0);
        send_pixel(PASS_STRETCH, 1'b1, 8'd255);
        send_pixel(PASS_MEASURE, 1'b1, 8'd0);
        send_pixel(PASS_MEASURE, 1'b0, 8'd255);
        send_pixel(PASS_STRETCH, 1'b0, 8'd0);
        send_pixel(PASS_STRETCH, 1'b0, 8'd255);
        send_pixel(PASS_STRETCH, 1'b0, 8'd128);
        send_pixel(PASS_STRETCH, 1'b0, 8'd1);
        send_pixel(PASS_STRETCH, 1'b0, 8'd254);
        send_pixel(PASS_MEASURE, 1'b1, 8'd100);
        send_pixel(PASS_STRETCH, 1'b0, 8'd100);
        send_pixel(PASS_STRETCH, 1'b0, 8'd7);
        send_pixel(PASS_MEASURE, 1'b0, 8'd200);
        send_pixel(PASS_STRETCH, 1'b0, 8'd50);
        send_pixel(PASS_STRETCH, 1'b0, 8'd250);
        send_pixel(PASS_STRETCH, 1'b0, 8'd150);
        send_pixel(PASS_STRETCH, 1'b1, 8'd150);
        drain_idle();
        set_levels(8'd255, 8'd0, 1'b1);
        send_pixel(PASS_STRETCH, 1'b0, 8'd100);
        send_pixel(PASS_STRETCH, 1'b0, 8'd200);
        send_pixel(PASS_STRETCH, 1'b0, 8'd133);
        send_pixel(PASS_STRETCH, 1'b0, 8'd199);
        send_pixel(PASS_MEASURE, 1'b1, 8'd255);
        send_pixel(PASS_MEASURE, 1'b0, 8'd0);
        send_pixel(PASS_STRETCH, 1'b0, 8'd77);
    endtask

    initial
    begin
        logic [LEVEL_W-1:0] flat_lvl;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        mode      = PASS_MEASURE;
        first     = 1'b0;
        pixel     = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_phase(0, 0, 8'd0, 8'd255, 300, 1'b0);
        run_phase(79, 0, LEVEL_W'($urandom_range(255)), LEVEL_W'($urandom_range(255)),
                  300, 1'b0);
        run_phase(0, 79, 8'd255, 8'd0, 300, 1'b0);
        flat_lvl = LEVEL_W'($urandom_range(255));
        run_phase(30, 30, flat_lvl, flat_lvl, 150, 1'b0);
        run_phase(0, 0, 8'd0, 8'd0, 250, 1'b1);
        run_phase(30, 30, 8'd255, 8'd255, 100, 1'b0);
        run_phase(30, 30, LEVEL_W'($urandom_range(255)), LEVEL_W'($urandom_range(255)),
                  230, 1'b0);
        drain_idle();

        if (n_failed == 0 && n_waiting == 0)
        begin
            $display("contrast_stretch_tb OK");
        end
        else
        begin
            $display("contrast_stretch_tb NOT OK");
        end
        $finish;
    end

endmodule
